// ===== rtl/pbs_pkg.sv =====
// Package for the priority batch scheduler: field widths, defaults, FSM state type.
// No dependencies; used by rtl/priority_batch_scheduler_core.sv.
package pbs_pkg;

    localparam int MAX_PROCS_DEF = 16;

    localparam int ARR_W  = 16;
    localparam int BUR_W  = 16;
    localparam int PRI_W  = 8;
    localparam int NUM_W  = 5;
    localparam int TOUT_W = 21;
    localparam int SUM_W  = 25;

    // one job table row: arrival, burst, priority
    localparam int ROW_W = ARR_W + BUR_W + PRI_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CALC,
        ST_EMIT
    } state_t;

endpackage

// ===== rtl/priority_batch_scheduler_core.sv =====
// Top level of the non-preemptive priority batch scheduler.
// Depends on rtl/pbs_pkg.sv (widths, state type).
//
//  channel   signals                                          handshake
//  --------  -----------------------------------------------  --------------------------
//  job in    arrival_time burst_time job_priority last_job    start & !busy
//  result    job_number start_time completion_time            result_valid, 1 cycle only
//            waiting_time turnaround_time total_waiting
//            total_turnaround overflow_flag final_result
//
// Loading: one job word per cycle while busy is low, written into the job table RAM.
// Scheduling, after the word with last_job: for each of the n jobs one full pass over
// the RAM (n reads, one per cycle, through the registered read port) finds the next job
// in run order, then ST_CALC computes its times and ST_EMIT emits the word.
// The single RAM read port is why each choice needs a full pass over the table.
// busy stays high from the last_job word until the cycle the final result appears.
// Reset clears all control state; the RAM needs no clearing, only loaded rows are read.
// The receiver cannot stall: each result is shown for exactly one cycle.
module priority_batch_scheduler_core #(
    parameter int MAX_PROCS = pbs_pkg::MAX_PROCS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [pbs_pkg::ARR_W-1:0] arrival_time,
    input  logic [pbs_pkg::BUR_W-1:0] burst_time,
    input  logic [pbs_pkg::PRI_W-1:0] job_priority,
    input  logic                      last_job,
    output logic                      result_valid,
    output logic [pbs_pkg::NUM_W-1:0] job_number,
    output logic [pbs_pkg::TOUT_W-1:0] start_time,
    output logic [pbs_pkg::TOUT_W-1:0] completion_time,
    output logic [pbs_pkg::TOUT_W-1:0] waiting_time,
    output logic [pbs_pkg::TOUT_W-1:0] turnaround_time,
    output logic [pbs_pkg::SUM_W-1:0] total_waiting,
    output logic [pbs_pkg::SUM_W-1:0] total_turnaround,
    output logic                      overflow_flag,
    output logic                      final_result
);

    // index into the table, and a count that can hold MAX_PROCS itself
    localparam int IW  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CW  = $clog2(MAX_PROCS + 1);
    // time never exceeds max arrival plus all bursts: 65535 * (MAX_PROCS + 1)
    localparam int TW  = pbs_pkg::ARR_W + CW;
    localparam int EW  = (TW > pbs_pkg::SUM_W) ? TW : pbs_pkg::SUM_W;
    // sort key: arrival, then priority, then job index (unique per batch)
    localparam int KW  = pbs_pkg::ARR_W + pbs_pkg::PRI_W + IW;
    localparam int AW  = pbs_pkg::ARR_W;
    localparam int BW  = pbs_pkg::BUR_W;
    localparam int PW  = pbs_pkg::PRI_W;
    localparam int RW  = pbs_pkg::ROW_W;

    // ---------------------------------------------------------------- job table RAM
    // Writes happen only while idle, read data is used only while scanning, so the two never
    // touch the same row in overlapping cycles and no forwarding is needed.
    logic [RW-1:0] job_mem [MAX_PROCS];
    logic          mem_we;
    logic [IW-1:0] mem_wa;
    logic [RW-1:0] mem_wd;
    logic [IW-1:0] mem_ra;
    logic [RW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            job_mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= job_mem[mem_ra];
    end

    // ---------------------------------------------------------------- control state
    pbs_pkg::state_t state_reg, state_next;

    logic [CW-1:0] count_reg;      // jobs loaded this batch
    logic          drop_reg;       // a job was dropped this batch
    logic [CW-1:0] iss_cnt_reg;    // next row to read in the current pass
    logic          rd_valid_reg;   // rd_data_reg holds a row of this pass
    logic [IW-1:0] rd_idx_reg;     // which row rd_data_reg holds
    logic [CW-1:0] emit_cnt_reg;   // results chosen so far
    logic          have_best_reg;
    logic          have_last_reg;
    logic [KW-1:0] best_key_reg;
    logic [BW-1:0] best_burst_reg;
    logic [KW-1:0] last_key_reg;   // key of the job emitted previously

    // datapath
    logic [TW-1:0] cur_time_reg;
    logic [TW-1:0] start_reg;
    logic [TW-1:0] wait_reg;
    logic [BW-1:0] burst_reg;
    logic [IW-1:0] job_idx_reg;
    logic [pbs_pkg::SUM_W-1:0] wsum_reg;
    logic [pbs_pkg::SUM_W-1:0] tsum_reg;

    // output registers
    logic                         res_valid_reg;
    logic [pbs_pkg::NUM_W-1:0]    res_num_reg;
    logic [pbs_pkg::TOUT_W-1:0]   res_start_reg;
    logic [pbs_pkg::TOUT_W-1:0]   res_done_reg;
    logic [pbs_pkg::TOUT_W-1:0]   res_wait_reg;
    logic [pbs_pkg::TOUT_W-1:0]   res_tat_reg;
    logic [pbs_pkg::SUM_W-1:0]    res_twait_reg;
    logic [pbs_pkg::SUM_W-1:0]    res_ttat_reg;
    logic                         res_ovf_reg;
    logic                         res_final_reg;

    logic accept;
    logic issue;
    logic pass_end;
    logic last_emit;

    assign accept    = start && (state_reg == pbs_pkg::ST_IDLE);
    assign issue     = (state_reg == pbs_pkg::ST_SCAN) && (iss_cnt_reg < count_reg);
    assign pass_end  = (state_reg == pbs_pkg::ST_SCAN) && rd_valid_reg
                       && (CW'(rd_idx_reg) == (count_reg - CW'(1)));
    assign last_emit = (emit_cnt_reg == count_reg);

    // ---------------------------------------------------------------- scan compare
    // A row is eligible if its key lies above the key emitted last; the smallest
    // eligible key of the pass is the next job to run.
    logic [AW-1:0] rd_arr;
    logic [BW-1:0] rd_bur;
    logic [PW-1:0] rd_pri;
    logic [KW-1:0] rd_key;
    logic          take_row;

    assign rd_arr   = rd_data_reg[RW-1 -: AW];
    assign rd_bur   = rd_data_reg[PW +: BW];
    assign rd_pri   = rd_data_reg[PW-1:0];
    assign rd_key   = {rd_arr, rd_pri, rd_idx_reg};
    assign take_row = rd_valid_reg
                      && (!have_last_reg || (rd_key > last_key_reg))
                      && (!have_best_reg || (rd_key < best_key_reg));

    // ---------------------------------------------------------------- time math
    logic [TW-1:0] best_arr_ext;
    logic [TW-1:0] start_calc;
    logic [TW-1:0] done_calc;
    logic [TW-1:0] tat_calc;
    logic [EW-1:0] wait_ext;
    logic [EW-1:0] tat_ext;
    logic [pbs_pkg::SUM_W-1:0] wsum_new;
    logic [pbs_pkg::SUM_W-1:0] tsum_new;
    logic [IW:0]   job_num_calc;

    assign best_arr_ext = TW'(best_key_reg[KW-1 -: AW]);
    assign start_calc   = (cur_time_reg > best_arr_ext) ? cur_time_reg : best_arr_ext;
    assign done_calc    = start_reg + TW'(burst_reg);
    assign tat_calc     = wait_reg + TW'(burst_reg);
    assign wait_ext     = EW'(wait_reg);
    assign tat_ext      = EW'(tat_calc);
    assign wsum_new     = wsum_reg + wait_ext[pbs_pkg::SUM_W-1:0];
    assign tsum_new     = tsum_reg + tat_ext[pbs_pkg::SUM_W-1:0];
    assign job_num_calc = {1'b0, job_idx_reg} + (IW+1)'(1);

    // ---------------------------------------------------------------- RAM ports
    assign mem_we = accept && (count_reg < CW'(MAX_PROCS));
    assign mem_wa = count_reg[IW-1:0];
    assign mem_wd = {arrival_time, burst_time, job_priority};
    assign mem_ra = iss_cnt_reg[IW-1:0];

    // ---------------------------------------------------------------- next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pbs_pkg::ST_IDLE:
            begin
                if (accept && last_job)
                begin
                    state_next = pbs_pkg::ST_SCAN;
                end
            end
            pbs_pkg::ST_SCAN:
            begin
                if (pass_end)
                begin
                    state_next = pbs_pkg::ST_CALC;
                end
            end
            pbs_pkg::ST_CALC:
            begin
                state_next = pbs_pkg::ST_EMIT;
            end
            pbs_pkg::ST_EMIT:
            begin
                state_next = last_emit ? pbs_pkg::ST_IDLE : pbs_pkg::ST_SCAN;
            end
            default:
            begin
                state_next = pbs_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------- outputs
    always_comb
    begin
        busy             = (state_reg != pbs_pkg::ST_IDLE);
        result_valid     = res_valid_reg;
        job_number       = res_num_reg;
        start_time       = res_start_reg;
        completion_time  = res_done_reg;
        waiting_time     = res_wait_reg;
        turnaround_time  = res_tat_reg;
        total_waiting    = res_twait_reg;
        total_turnaround = res_ttat_reg;
        overflow_flag    = res_ovf_reg;
        final_result     = res_final_reg;
    end

    // ---------------------------------------------------------------- control regs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pbs_pkg::ST_IDLE;
            count_reg     <= '0;
            drop_reg      <= 1'b0;
            iss_cnt_reg   <= '0;
            rd_valid_reg  <= 1'b0;
            rd_idx_reg    <= '0;
            emit_cnt_reg  <= '0;
            have_best_reg <= 1'b0;
            have_last_reg <= 1'b0;
            cur_time_reg  <= '0;
            wsum_reg      <= '0;
            tsum_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= (state_reg == pbs_pkg::ST_EMIT);

            // read pipeline: row index travels alongside the RAM latency
            rd_valid_reg <= issue;
            if (issue)
            begin
                rd_idx_reg  <= iss_cnt_reg[IW-1:0];
                iss_cnt_reg <= iss_cnt_reg + CW'(1);
            end

            if (take_row)
            begin
                have_best_reg <= 1'b1;
            end

            unique case (state_reg)
                pbs_pkg::ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (count_reg < CW'(MAX_PROCS))
                        begin
                            count_reg <= count_reg + CW'(1);
                        end
                        else
                        begin
                            drop_reg <= 1'b1;
                        end
                    end
                    iss_cnt_reg   <= '0;
                    emit_cnt_reg  <= '0;
                    have_best_reg <= 1'b0;
                    have_last_reg <= 1'b0;
                end
                pbs_pkg::ST_SCAN:
                begin
                end
                pbs_pkg::ST_CALC:
                begin
                    have_last_reg <= 1'b1;
                    emit_cnt_reg  <= emit_cnt_reg + CW'(1);
                end
                pbs_pkg::ST_EMIT:
                begin
                    iss_cnt_reg   <= '0;
                    have_best_reg <= 1'b0;
                    if (last_emit)
                    begin
                        // batch done: back to empty
                        count_reg    <= '0;
                        drop_reg     <= 1'b0;
                        cur_time_reg <= '0;
                        wsum_reg     <= '0;
                        tsum_reg     <= '0;
                    end
                    else
                    begin
                        cur_time_reg <= done_calc;
                        wsum_reg     <= wsum_new;
                        tsum_reg     <= tsum_new;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------- payload regs
    always_ff @(posedge clk)
    begin
        if (take_row)
        begin
            best_key_reg   <= rd_key;
            best_burst_reg <= rd_bur;
        end

        if (state_reg == pbs_pkg::ST_CALC)
        begin
            last_key_reg <= best_key_reg;
            start_reg    <= start_calc;
            wait_reg     <= start_calc - best_arr_ext;
            burst_reg    <= best_burst_reg;
            job_idx_reg  <= best_key_reg[IW-1:0];
        end

        if (state_reg == pbs_pkg::ST_EMIT)
        begin
            res_num_reg   <= pbs_pkg::NUM_W'(job_num_calc);
            res_start_reg <= pbs_pkg::TOUT_W'(start_reg);
            res_done_reg  <= pbs_pkg::TOUT_W'(done_calc);
            res_wait_reg  <= pbs_pkg::TOUT_W'(wait_reg);
            res_tat_reg   <= pbs_pkg::TOUT_W'(tat_calc);
            res_twait_reg <= last_emit ? wsum_new : '0;
            res_ttat_reg  <= last_emit ? tsum_new : '0;
            res_ovf_reg   <= drop_reg;
            res_final_reg <= last_emit;
        end
    end

endmodule

// ===== rtl/pbs_checker.sv =====
// Port-level checks for priority_batch_scheduler_core, bound to every instance.
// Depends on rtl/pbs_pkg.sv and rtl/priority_batch_scheduler_core.sv.
module pbs_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        last_job,
    input logic                        result_valid,
    input logic [pbs_pkg::SUM_W-1:0]   total_waiting,
    input logic [pbs_pkg::SUM_W-1:0]   total_turnaround,
    input logic                        final_result
);

    // closing word of a batch starts scheduling
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && last_job |=> busy)
        else $error("busy not raised after last job word");

    // more results to come: block stays busy
    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !final_result |-> busy)
        else $error("idle with results outstanding");

    // totals appear only on the final word
    a_tot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !final_result |-> (total_waiting == '0) && (total_turnaround == '0))
        else $error("totals on non-final word");

    // nothing emitted out of idle
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> !result_valid)
        else $error("result word out of idle");

endmodule

bind priority_batch_scheduler_core pbs_checker u_pbs_checker (.*);
